// ===== rtl/core/wppb_pkg.sv =====
// ----------------------------------------------------------------------------
// wppb_pkg
// Shared types and constants of the weighted palette pixel blend core:
// field widths, palette, pipeline control word and register indexes.
// ----------------------------------------------------------------------------
package wppb_pkg;

	localparam int NUM_INPUTS = 8;
	localparam int NUM_COLORS = 8;
	localparam int NUM_CH     = 3;
	localparam int IN_BITS    = 16;
	localparam int Q_BITS     = 8;
	localparam int CFG_BITS   = 4;
	localparam int IDX_BITS   = 2;

	localparam logic MODE_GREY = 1'b1;

	typedef enum logic [IDX_BITS-1:0] {
		CFG_MODE   = 2'd0,
		CFG_PLANES = 2'd1,
		CFG_SELECT = 2'd2
	} cfg_idx_t;

	// red, green, blue per plane
	localparam logic [Q_BITS-1:0] PALETTE [NUM_COLORS][NUM_CH] = '{
		'{8'd255, 8'd0,   8'd0  },
		'{8'd0,   8'd255, 8'd0  },
		'{8'd0,   8'd0,   8'd255},
		'{8'd255, 8'd255, 8'd0  },
		'{8'd255, 8'd0,   8'd255},
		'{8'd0,   8'd255, 8'd255},
		'{8'd127, 8'd127, 8'd127},
		'{8'd255, 8'd255, 8'd255}
	};

	localparam logic [Q_BITS-1:0] GREY_LEVEL = 8'd255;

	typedef struct packed {
		logic valid;
		logic mode;
		logic zero;
	} pix_ctl_t;

	// every color has one common level on its nonzero channels
	function automatic logic [Q_BITS-1:0] lane_level(input logic [2:0] idx);
		logic [Q_BITS-1:0] lv;
		lv = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			if (PALETTE[idx][c] > lv) begin
				lv = PALETTE[idx][c];
			end
		end
		return lv;
	endfunction

endpackage

// ===== rtl/core/wppb_lane.sv =====
// ----------------------------------------------------------------------------
// wppb_lane
// Pipelined restoring divider, one quotient bit per stage, giving
// floor(num / den) saturated to the quotient width.
// ----------------------------------------------------------------------------
module wppb_lane #(
	parameter int NUM_BITS = 24,
	parameter int DEN_BITS = 19
) (
	input  logic                        clk,
	input  logic [NUM_BITS-1:0]         num,
	input  logic [DEN_BITS-1:0]         den,
	output logic [wppb_pkg::Q_BITS-1:0] quot
);
	import wppb_pkg::*;

	localparam int WW = (NUM_BITS > DEN_BITS + Q_BITS) ? NUM_BITS : DEN_BITS + Q_BITS;

	logic [NUM_BITS-1:0] rem_s  [Q_BITS];
	logic [DEN_BITS-1:0] den_s  [Q_BITS];
	logic [Q_BITS-1:0]   quot_s [Q_BITS];
	logic                ovf_s  [Q_BITS];

	logic [NUM_BITS-1:0] rem_in  [Q_BITS];
	logic [DEN_BITS-1:0] den_in  [Q_BITS];
	logic [Q_BITS-1:0]   quot_in [Q_BITS];
	logic                ovf_in  [Q_BITS];

	for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
		localparam int K = Q_BITS - 1 - j;

		logic [WW-1:0]       dsh;
		logic [WW-1:0]       rw;
		logic                ge;
		logic [NUM_BITS-1:0] rem_nx;
		logic [Q_BITS-1:0]   quot_nx;

		if (j == 0) begin : g_first
			assign rem_in[j]  = num;
			assign den_in[j]  = den;
			assign quot_in[j] = '0;
			// quotient would not fit
			assign ovf_in[j]  = WW'(num) >= (WW'(den) << Q_BITS);
		end else begin : g_next
			assign rem_in[j]  = rem_s[j-1];
			assign den_in[j]  = den_s[j-1];
			assign quot_in[j] = quot_s[j-1];
			assign ovf_in[j]  = ovf_s[j-1];
		end

		assign dsh     = WW'(den_in[j]) << K;
		assign rw      = WW'(rem_in[j]);
		assign ge      = rw >= dsh;
		assign rem_nx  = ge ? NUM_BITS'(rw - dsh) : rem_in[j];
		assign quot_nx = quot_in[j] | (Q_BITS'(ge) << K);

		always_ff @(posedge clk) begin
			rem_s[j]  <= rem_nx;
			den_s[j]  <= den_in[j];
			quot_s[j] <= quot_nx;
			ovf_s[j]  <= ovf_in[j];
		end
	end

	assign quot = ovf_s[Q_BITS-1] ? '1 : quot_s[Q_BITS-1];

endmodule

// ===== rtl/core/wppb_merge.sv =====
// ----------------------------------------------------------------------------
// wppb_merge
// Combines the lane quotients into one RGB pixel, selects grey mode or
// black, and registers the result with its strobe.
// ----------------------------------------------------------------------------
module wppb_merge #(
	parameter int MAX_PLANES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wppb_pkg::pix_ctl_t          ctl,
	input  logic [wppb_pkg::Q_BITS-1:0] quot [MAX_PLANES],
	input  logic [wppb_pkg::Q_BITS-1:0] grey,
	output logic [wppb_pkg::Q_BITS-1:0] red,
	output logic [wppb_pkg::Q_BITS-1:0] green,
	output logic [wppb_pkg::Q_BITS-1:0] blue,
	output logic                        done
);
	import wppb_pkg::*;

	localparam int AW = Q_BITS + $clog2(MAX_PLANES) + 1;
	localparam logic [AW-1:0] CH_MAX = AW'((1 << Q_BITS) - 1);

	logic [AW-1:0]     acc   [NUM_CH];
	logic [Q_BITS-1:0] pix_c [NUM_CH];
	logic [Q_BITS-1:0] red_q;
	logic [Q_BITS-1:0] green_q;
	logic [Q_BITS-1:0] blue_q;
	logic              done_q;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			acc[c] = '0;
			for (int i = 0; i < MAX_PLANES; i++) begin
				if (PALETTE[i][c] != '0) begin
					acc[c] = acc[c] + AW'(quot[i]);
				end
			end
			priority if (ctl.zero) begin
				pix_c[c] = '0;
			end else if (ctl.mode == MODE_GREY) begin
				pix_c[c] = grey;
			end else if (acc[c] > CH_MAX) begin
				pix_c[c] = '1;
			end else begin
				pix_c[c] = acc[c][Q_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		red_q   <= pix_c[0];
		green_q <= pix_c[1];
		blue_q  <= pix_c[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.valid;
		end
	end

	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;
	assign done  = done_q;

endmodule

// ===== rtl/core/weighted_palette_pixel_blend_core.sv =====
// ----------------------------------------------------------------------------
// weighted_palette_pixel_blend_core
// Blends the per-plane counts of one pixel into an RGB value by palette
// weight, or shows one plane's share as grey.
//
//   channel   signals                              transaction
//   input     start, busy, count_0 .. count_7      start && !busy
//   config    cfg_valid, cfg_ready, cfg_index,     cfg_valid && cfg_ready
//             cfg_data
//   result    done, red, green, blue               done, one cycle
//
// one pixel per cycle; input, product and sum registers, then the divider
// lanes, one quotient bit per stage, one lane per plane plus a grey lane
// busy stays low and cfg_ready stays high: every cycle can take a pixel
// arst_n clears the register file to its defaults and flushes the pipeline
// results are shown for one cycle and are never held back
// ----------------------------------------------------------------------------
module weighted_palette_pixel_blend_core #(
	parameter int MAX_PLANES = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [wppb_pkg::IN_BITS-1:0]  count_0,
	input  logic [wppb_pkg::IN_BITS-1:0]  count_1,
	input  logic [wppb_pkg::IN_BITS-1:0]  count_2,
	input  logic [wppb_pkg::IN_BITS-1:0]  count_3,
	input  logic [wppb_pkg::IN_BITS-1:0]  count_4,
	input  logic [wppb_pkg::IN_BITS-1:0]  count_5,
	input  logic [wppb_pkg::IN_BITS-1:0]  count_6,
	input  logic [wppb_pkg::IN_BITS-1:0]  count_7,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wppb_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [wppb_pkg::CFG_BITS-1:0] cfg_data,
	output logic                          done,
	output logic [wppb_pkg::Q_BITS-1:0]   red,
	output logic [wppb_pkg::Q_BITS-1:0]   green,
	output logic [wppb_pkg::Q_BITS-1:0]   blue
);
	import wppb_pkg::*;

	localparam int CW = (COUNT_BITS < IN_BITS) ? COUNT_BITS : IN_BITS;
	localparam int SW = CW + $clog2(MAX_PLANES);
	localparam int NW = CW + Q_BITS;

	logic          mode_q;
	logic [3:0]    planes_q;
	logic [2:0]    sel_q;

	logic [IN_BITS-1:0] cnt_in [NUM_INPUTS];
	logic [CW-1:0]      cnt_c  [MAX_PLANES];
	logic               zero_c;
	logic [SW-1:0]      sum_c;

	logic [CW-1:0]  cnt_s1 [MAX_PLANES];
	logic [CW-1:0]  grey_s1;
	logic [SW-1:0]  sum_s2;
	logic [NW-1:0]  num_s2 [MAX_PLANES];
	logic [NW-1:0]  grey_num_s2;

	pix_ctl_t ctl_s1;
	pix_ctl_t ctl_s2;
	pix_ctl_t ctl_d [Q_BITS];

	logic [Q_BITS-1:0] quot [MAX_PLANES];
	logic [Q_BITS-1:0] grey_quot;
	logic              accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	assign cnt_in[0] = count_0;
	assign cnt_in[1] = count_1;
	assign cnt_in[2] = count_2;
	assign cnt_in[3] = count_3;
	assign cnt_in[4] = count_4;
	assign cnt_in[5] = count_5;
	assign cnt_in[6] = count_6;
	assign cnt_in[7] = count_7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			planes_q <= 4'd8;
			sel_q    <= 3'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[0];
				CFG_PLANES: planes_q <= cfg_data[3:0];
				CFG_SELECT: sel_q    <= cfg_data[2:0];
				default:    ;
			endcase
		end
	end

	// planes at index planes_q and above contribute nothing
	always_comb begin
		zero_c = 1'b1;
		for (int i = 0; i < MAX_PLANES; i++) begin
			cnt_c[i] = (4'(i) < planes_q) ? cnt_in[i][CW-1:0] : '0;
			if (cnt_c[i] != '0) begin
				zero_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_PLANES; i++) begin
			cnt_s1[i] <= cnt_c[i];
		end
		grey_s1 <= cnt_in[sel_q][CW-1:0];
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < MAX_PLANES; i++) begin
			sum_c = sum_c + SW'(cnt_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum_c;
		for (int i = 0; i < MAX_PLANES; i++) begin
			num_s2[i] <= NW'(cnt_s1[i]) * NW'(lane_level(3'(i)));
		end
		grey_num_s2 <= NW'(grey_s1) * NW'(GREY_LEVEL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			for (int j = 0; j < Q_BITS; j++) begin
				ctl_d[j] <= '0;
			end
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.mode  <= mode_q;
			ctl_s1.zero  <= zero_c;
			ctl_s2       <= ctl_s1;
			ctl_d[0]     <= ctl_s2;
			for (int j = 1; j < Q_BITS; j++) begin
				ctl_d[j] <= ctl_d[j-1];
			end
		end
	end

	for (genvar i = 0; i < MAX_PLANES; i++) begin : g_lane
		wppb_lane #(
			.NUM_BITS (NW),
			.DEN_BITS (SW)
		) u_lane (
			.clk  (clk),
			.num  (num_s2[i]),
			.den  (sum_s2),
			.quot (quot[i])
		);
	end

	wppb_lane #(
		.NUM_BITS (NW),
		.DEN_BITS (SW)
	) u_grey_lane (
		.clk  (clk),
		.num  (grey_num_s2),
		.den  (sum_s2),
		.quot (grey_quot)
	);

	wppb_merge #(
		.MAX_PLANES (MAX_PLANES)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_d[Q_BITS-1]),
		.quot   (quot),
		.grey   (grey_quot),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.done   (done)
	);

endmodule

// ===== rtl/core/wppb_checker.sv =====
// ----------------------------------------------------------------------------
// wppb_checker
// Port-level checks of the blend core: fixed latency between an accepted
// pixel and its result, and black output for an all-zero pixel.
// ----------------------------------------------------------------------------
module wppb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [wppb_pkg::IN_BITS-1:0] count_0,
	input logic [wppb_pkg::IN_BITS-1:0] count_1,
	input logic [wppb_pkg::IN_BITS-1:0] count_2,
	input logic [wppb_pkg::IN_BITS-1:0] count_3,
	input logic [wppb_pkg::IN_BITS-1:0] count_4,
	input logic [wppb_pkg::IN_BITS-1:0] count_5,
	input logic [wppb_pkg::IN_BITS-1:0] count_6,
	input logic [wppb_pkg::IN_BITS-1:0] count_7,
	input logic                         done,
	input logic [wppb_pkg::Q_BITS-1:0]  red,
	input logic [wppb_pkg::Q_BITS-1:0]  green,
	input logic [wppb_pkg::Q_BITS-1:0]  blue
);
	import wppb_pkg::*;

	localparam int LATENCY = Q_BITS + 3;

	logic all_zero;

	assign all_zero = (count_0 == '0) && (count_1 == '0) && (count_2 == '0) &&
		(count_3 == '0) && (count_4 == '0) && (count_5 == '0) &&
		(count_6 == '0) && (count_7 == '0);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted pixel gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without an accepted pixel");

	a_zero_black: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && all_zero) |-> ##LATENCY
		(red == '0 && green == '0 && blue == '0))
		else $error("all-zero pixel did not give black");

endmodule

bind weighted_palette_pixel_blend_core wppb_checker u_checker (.*);
